// File: sv/pfc_pkg.sv
// pfc_pkg: shared types, constants and helper functions for the pixel format converter
// no dependencies; imported by pfc_luma and pixel_format_converter

package pfc_pkg;

  // pixel format codes, as held in the source and target format registers
  typedef enum logic [2:0] {
    FMT_A8       = 3'd0,
    FMT_I8       = 3'd1,
    FMT_IA88     = 3'd2,
    FMT_RGB888   = 3'd3,
    FMT_RGBA8888 = 3'd4
  } fmt_t;

  // configuration register indexes (byte address / 4)
  localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
  localparam logic [1:0] REG_TARGET_FORMAT = 2'd1;
  localparam logic [1:0] REG_TRUNCATE_MODE = 2'd2;

  // reset values of the configuration registers
  localparam logic [2:0] SOURCE_FORMAT_RESET = 3'd4;
  localparam logic [2:0] TARGET_FORMAT_RESET = 3'd4;
  localparam logic       TRUNCATE_MODE_RESET = 1'b0;

  // luma weights and rounding term, scaled by 1000
  localparam int LUMA_W_R   = 299;
  localparam int LUMA_W_G   = 587;
  localparam int LUMA_W_B   = 114;
  localparam int LUMA_ROUND = 500;

  // weighted sum is at most 255 * 1000 + 500, fits 18 bits
  localparam int LUMA_SUM_W = 18;

  // divide by 1000: multiply by ceil(2^28 / 1000) and shift, exact for 18-bit sums
  localparam int LUMA_SHIFT   = 28;
  localparam int LUMA_RECIP_W = 19;
  localparam logic [LUMA_RECIP_W-1:0] LUMA_RECIP = 19'd268436;
  localparam int LUMA_PROD_W  = LUMA_SUM_W + LUMA_RECIP_W;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // codes above the highest format saturate to RGBA8888
  function automatic fmt_t clamp_fmt(input logic [2:0] code);
    fmt_t f;
    if (code > 3'(FMT_RGBA8888)) begin
      f = FMT_RGBA8888;
    end else begin
      f = fmt_t'(code);
    end
    return f;
  endfunction

  // bytes per pixel of a format
  function automatic logic [2:0] bytes_of(input fmt_t f);
    logic [2:0] n;
    case (f)
      FMT_A8:     n = 3'd1;
      FMT_I8:     n = 3'd1;
      FMT_IA88:   n = 3'd2;
      FMT_RGB888: n = 3'd3;
      default:    n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

// File: sv/pfc_luma.sv
// pfc_luma: two-step luma, registered weighted sum then exact divide by 1000
// depends on pfc_pkg for the weights and the reciprocal constant

module pfc_luma (
  input  logic       clk,
  input  logic [7:0] r,
  input  logic [7:0] g,
  input  logic [7:0] b,
  output logic [7:0] y
);
  import pfc_pkg::*;

  logic [LUMA_SUM_W-1:0]  sum_nxt;
  logic [LUMA_SUM_W-1:0]  sum_r;
  logic [LUMA_PROD_W-1:0] prod;

  // weighted sum with rounding term
  assign sum_nxt = LUMA_SUM_W'(r) * LUMA_SUM_W'(LUMA_W_R)
                 + LUMA_SUM_W'(g) * LUMA_SUM_W'(LUMA_W_G)
                 + LUMA_SUM_W'(b) * LUMA_SUM_W'(LUMA_W_B)
                 + LUMA_SUM_W'(LUMA_ROUND);

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  // reciprocal multiply, quotient is below 256
  assign prod = LUMA_PROD_W'(sum_r) * LUMA_PROD_W'(LUMA_RECIP);
  assign y    = prod[LUMA_SHIFT +: 8];

endmodule

// File: sv/pixel_format_converter.sv
// pixel_format_converter: one pixel per clock between A8, I8, IA88, RGB888, RGBA8888
// depends on pfc_pkg and pfc_luma
// a pixel passes the input register, the luma sum register and the result register before its out_valid strobe
// throughput: one pixel per clock, busy is never raised; the luma path is split over
//   two stages (weighted sum register, then reciprocal multiply into the result register)
// reset: formats RGBA8888 to RGBA8888, conversion mode, pipeline emptied
// results are strobed for one cycle and cannot be held off by the receiver

module pixel_format_converter (
  input  logic        clk,
  input  logic        rst_n,
  // input transactions
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_byte_0,
  input  logic [7:0]  in_byte_1,
  input  logic [7:0]  in_byte_2,
  input  logic [7:0]  in_byte_3,
  input  logic        in_last_in_line,
  // result transactions
  output logic        out_valid,
  output logic [7:0]  out_byte_0,
  output logic [7:0]  out_byte_1,
  output logic [7:0]  out_byte_2,
  output logic [7:0]  out_byte_3,
  output logic [2:0]  out_count,
  output logic        out_line_end,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pfc_pkg::*;

  logic       accept;
  logic       cfg_write;
  logic [1:0] cfg_index;

  logic [2:0] src_fmt_r;
  logic [2:0] tgt_fmt_r;
  logic       trunc_r;

  logic       v1_r, v2_r, v3_r;
  logic [7:0] b1_r [4];
  logic [7:0] b2_r [4];
  logic       last1_r, last2_r;

  logic [7:0] luma_y;
  fmt_t       s_fmt, t_fmt;
  logic [2:0] ns, nt, ncopy;
  logic [7:0] o_nxt [4];

  logic [7:0] ob_r [4];
  logic [2:0] count_r;
  logic       line_end_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pready = 1'b1;

  // configuration registers
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= SOURCE_FORMAT_RESET;
      tgt_fmt_r <= TARGET_FORMAT_RESET;
      trunc_r   <= TRUNCATE_MODE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SOURCE_FORMAT: src_fmt_r <= pwdata[2:0];
        REG_TARGET_FORMAT: tgt_fmt_r <= pwdata[2:0];
        REG_TRUNCATE_MODE: trunc_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_index)
      REG_SOURCE_FORMAT: prdata = {29'd0, src_fmt_r};
      REG_TARGET_FORMAT: prdata = {29'd0, tgt_fmt_r};
      REG_TRUNCATE_MODE: prdata = {31'd0, trunc_r};
      default:           prdata = 32'd0;
    endcase
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // input register and byte delay alongside the luma sum
  always_ff @(posedge clk) begin
    if (accept) begin
      b1_r[0] <= in_byte_0;
      b1_r[1] <= in_byte_1;
      b1_r[2] <= in_byte_2;
      b1_r[3] <= in_byte_3;
      last1_r <= in_last_in_line;
    end
    b2_r    <= b1_r;
    last2_r <= last1_r;
  end

  pfc_luma u_luma (
    .clk (clk),
    .r   (b1_r[0]),
    .g   (b1_r[1]),
    .b   (b1_r[2]),
    .y   (luma_y)
  );

  // format sizes
  assign s_fmt = clamp_fmt(src_fmt_r);
  assign t_fmt = clamp_fmt(tgt_fmt_r);
  assign ns    = bytes_of(s_fmt);
  assign nt    = bytes_of(t_fmt);
  assign ncopy = (ns < nt) ? ns : nt;

  // conversion select
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      o_nxt[k] = 8'd0;
    end
    if (s_fmt == t_fmt || trunc_r) begin
      // leading bytes copied, the rest zero
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < ncopy) begin
          o_nxt[k] = b2_r[k];
        end
      end
    end else begin
      case (s_fmt)
        FMT_A8: begin
          if (t_fmt == FMT_I8) begin
            o_nxt[0] = b2_r[0];
          end else if (t_fmt == FMT_IA88) begin
            o_nxt[0] = ALPHA_OPAQUE;
            o_nxt[1] = b2_r[0];
          end else if (t_fmt == FMT_RGBA8888) begin
            o_nxt[3] = b2_r[0];
          end
        end
        FMT_I8: begin
          o_nxt[0] = b2_r[0];
          if (t_fmt == FMT_IA88) begin
            o_nxt[1] = ALPHA_OPAQUE;
          end else if (t_fmt != FMT_A8) begin
            o_nxt[1] = b2_r[0];
            o_nxt[2] = b2_r[0];
            if (t_fmt == FMT_RGBA8888) begin
              o_nxt[3] = ALPHA_OPAQUE;
            end
          end
        end
        FMT_IA88: begin
          if (t_fmt == FMT_A8) begin
            o_nxt[0] = b2_r[1];
          end else if (t_fmt == FMT_I8) begin
            o_nxt[0] = b2_r[0];
          end else begin
            o_nxt[0] = b2_r[0];
            o_nxt[1] = b2_r[0];
            o_nxt[2] = b2_r[0];
            if (t_fmt == FMT_RGBA8888) begin
              o_nxt[3] = b2_r[1];
            end
          end
        end
        FMT_RGB888: begin
          if (t_fmt == FMT_I8) begin
            o_nxt[0] = luma_y;
          end else if (t_fmt == FMT_IA88) begin
            o_nxt[0] = luma_y;
            o_nxt[1] = ALPHA_OPAQUE;
          end else if (t_fmt == FMT_RGBA8888) begin
            o_nxt[0] = b2_r[0];
            o_nxt[1] = b2_r[1];
            o_nxt[2] = b2_r[2];
            o_nxt[3] = ALPHA_OPAQUE;
          end
        end
        default: begin
          // RGBA8888 source
          if (t_fmt == FMT_A8) begin
            o_nxt[0] = b2_r[3];
          end else if (t_fmt == FMT_I8) begin
            o_nxt[0] = luma_y;
          end else if (t_fmt == FMT_IA88) begin
            o_nxt[0] = luma_y;
            o_nxt[1] = b2_r[3];
          end else begin
            o_nxt[0] = b2_r[0];
            o_nxt[1] = b2_r[1];
            o_nxt[2] = b2_r[2];
          end
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    ob_r       <= o_nxt;
    count_r    <= nt;
    line_end_r <= last2_r;
  end

  assign out_valid    = v3_r;
  assign out_byte_0   = ob_r[0];
  assign out_byte_1   = ob_r[1];
  assign out_byte_2   = ob_r[2];
  assign out_byte_3   = ob_r[3];
  assign out_count    = count_r;
  assign out_line_end = line_end_r;

  // every accepted transaction passes through v2_r and is then strobed out on out_valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 v2_r ##1 out_valid)
    else $error("accepted pixel not delivered after three cycles");

  // no result without a matching input transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(v2_r) && $past(v1_r, 2))
    else $error("result strobe without accepted pixel");

  // byte count is a real pixel size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count >= 3'd1 && out_count <= 3'd4))
    else $error("out_count outside 1 to 4");

  // bytes beyond the target size are zero
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count == 3'd4 || out_byte_3 == 8'd0)
               && (out_count >= 3'd3 || out_byte_2 == 8'd0)
               && (out_count >= 3'd2 || out_byte_1 == 8'd0))
    else $error("unused output byte not zero");

endmodule

// File: dv/pixel_format_converter_checker.sv
// pixel_format_converter_checker: watches the config, pixel and result channels,
// predicts each converted pixel and compares it with the strobed result
// depends on pfc_pkg for the format codes, register indexes and reset values
`timescale 1ns / 100ps

module pixel_format_converter_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [7:0]  in_byte_0,
  input  logic [7:0]  in_byte_1,
  input  logic [7:0]  in_byte_2,
  input  logic [7:0]  in_byte_3,
  input  logic        in_last_in_line,
  input  logic        out_valid,
  input  logic [7:0]  out_byte_0,
  input  logic [7:0]  out_byte_1,
  input  logic [7:0]  out_byte_2,
  input  logic [7:0]  out_byte_3,
  input  logic [2:0]  out_count,
  input  logic        out_line_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending,
  output int          results_checked
);

  import pfc_pkg::*;

  localparam int WEIGHT_R = 299;
  localparam int WEIGHT_G = 587;
  localparam int WEIGHT_B = 114;
  localparam int HALF_UNIT = 500;
  localparam int UNIT = 1000;
  localparam logic [7:0] OPAQUE = 8'hFF;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [2:0] count;
    logic       line_end;
  } pixel_out_t;

  // shadow copy of the configuration registers
  logic [2:0] src_code_q;
  logic [2:0] tgt_code_q;
  logic       trunc_q;

  pixel_out_t expected_px_q [$];

  // codes 5 to 7 behave as RGBA8888
  function automatic fmt_t sat_format(input logic [2:0] code);
    return (code >= 3'd5) ? FMT_RGBA8888 : fmt_t'(code);
  endfunction

  function automatic int unsigned pixel_size(input fmt_t f);
    int unsigned n;
    case (f)
      FMT_A8, FMT_I8: n = 1;
      FMT_IA88:       n = 2;
      FMT_RGB888:     n = 3;
      default:        n = 4;
    endcase
    return n;
  endfunction

  // expected result of one pixel under the given settings
  function automatic pixel_out_t convert_pixel(input logic [2:0] src_code,
                                               input logic [2:0] tgt_code,
                                               input logic trunc,
                                               input logic [3:0][7:0] px,
                                               input logic eol);
    fmt_t s;
    fmt_t t;
    int unsigned ns;
    int unsigned nt;
    int unsigned y;
    logic [7:0] i;
    logic [7:0] yb;
    logic [3:0][7:0] o;
    pixel_out_t r;
    s = sat_format(src_code);
    t = sat_format(tgt_code);
    ns = pixel_size(s);
    nt = pixel_size(t);
    o = '0;
    i = px[0];
    y = (int'(px[0]) * WEIGHT_R + int'(px[1]) * WEIGHT_G + int'(px[2]) * WEIGHT_B
         + HALF_UNIT) / UNIT;
    yb = y[7:0];
    if (s == t || trunc) begin
      // plain copy of the leading bytes, rest stays zero
      for (int k = 0; k < 4; k++) begin
        if (k < ns && k < nt) o[k] = px[k];
      end
    end else begin
      case (s)
        FMT_A8: begin
          case (t)
            FMT_I8:       o[0] = px[0];
            FMT_IA88:     begin o[0] = OPAQUE; o[1] = px[0]; end
            FMT_RGBA8888: o[3] = px[0];
            default: ;
          endcase
        end
        FMT_I8: begin
          case (t)
            FMT_A8:   o[0] = i;
            FMT_IA88: begin o[0] = i; o[1] = OPAQUE; end
            default: begin
              o[0] = i; o[1] = i; o[2] = i;
              if (t == FMT_RGBA8888) o[3] = OPAQUE;
            end
          endcase
        end
        FMT_IA88: begin
          case (t)
            FMT_A8: o[0] = px[1];
            FMT_I8: o[0] = i;
            default: begin
              o[0] = i; o[1] = i; o[2] = i;
              if (t == FMT_RGBA8888) o[3] = px[1];
            end
          endcase
        end
        FMT_RGB888: begin
          case (t)
            FMT_I8:       o[0] = yb;
            FMT_IA88:     begin o[0] = yb; o[1] = OPAQUE; end
            FMT_RGBA8888: begin o[0] = px[0]; o[1] = px[1]; o[2] = px[2]; o[3] = OPAQUE; end
            default: ;
          endcase
        end
        default: begin
          case (t)
            FMT_A8:   o[0] = px[3];
            FMT_I8:   o[0] = yb;
            FMT_IA88: begin o[0] = yb; o[1] = px[3]; end
            default:  begin o[0] = px[0]; o[1] = px[1]; o[2] = px[2]; end
          endcase
        end
      endcase
    end
    r.b0 = o[0];
    r.b1 = o[1];
    r.b2 = o[2];
    r.b3 = o[3];
    r.count = 3'(nt);
    r.line_end = eol;
    return r;
  endfunction

  task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    pixel_out_t want;
    if (!rst_n) begin
      src_code_q = SOURCE_FORMAT_RESET;
      tgt_code_q = TARGET_FORMAT_RESET;
      trunc_q = TRUNCATE_MODE_RESET;
      expected_px_q.delete();
    end else begin
      // compare a strobed result with the oldest prediction
      if (out_valid === 1'b1) begin
        if (expected_px_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, actual %h %h %h %h count %0d",
                   $time, out_byte_0, out_byte_1, out_byte_2, out_byte_3, out_count);
        end else begin
          want = expected_px_q.pop_front();
          results_checked++;
          report_field("out_byte_0", want.b0, out_byte_0);
          report_field("out_byte_1", want.b1, out_byte_1);
          report_field("out_byte_2", want.b2, out_byte_2);
          report_field("out_byte_3", want.b3, out_byte_3);
          report_field("out_count", 8'(want.count), 8'(out_count));
          report_field("out_line_end", 8'(want.line_end), 8'(out_line_end));
        end
      end else if (out_valid !== 1'b0) begin
        errors++;
        $display("%0t: out_valid unknown, expected 0 or 1 actual %b", $time, out_valid);
      end

      // configuration write transaction
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SOURCE_FORMAT: src_code_q = pwdata[2:0];
          REG_TARGET_FORMAT: tgt_code_q = pwdata[2:0];
          REG_TRUNCATE_MODE: trunc_q = pwdata[0];
          default: ;
        endcase
      end

      // accepted pixel transaction
      if (start && !busy) begin
        expected_px_q.push_back(convert_pixel(src_code_q, tgt_code_q, trunc_q,
                                              {in_byte_3, in_byte_2, in_byte_1, in_byte_0},
                                              in_last_in_line));
      end
    end
    pending = expected_px_q.size();
  end

endmodule

// File: dv/pixel_format_converter_tb.sv
// pixel_format_converter_tb: clock, reset, config writes and pixel stimulus for the
// converter; checking is done by pixel_format_converter_checker, depends on pfc_pkg
`timescale 1ns / 100ps

module pixel_format_converter_tb;

  import pfc_pkg::*;

  localparam int LATENCY = 3;
  localparam int PHASES = 65;
  localparam int PIXELS_PER_PHASE = 20;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_byte_0;
  logic [7:0]  in_byte_1;
  logic [7:0]  in_byte_2;
  logic [7:0]  in_byte_3;
  logic        in_last_in_line;
  logic        out_valid;
  logic [7:0]  out_byte_0;
  logic [7:0]  out_byte_1;
  logic [7:0]  out_byte_2;
  logic [7:0]  out_byte_3;
  logic [2:0]  out_count;
  logic        out_line_end;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int chk_errors;
  int chk_pending;
  int chk_checked;
  int pixels_sent;
  int settings_applied;
  int send_idle_pct;

  pixel_format_converter dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_byte_0(in_byte_0), .in_byte_1(in_byte_1),
    .in_byte_2(in_byte_2), .in_byte_3(in_byte_3),
    .in_last_in_line(in_last_in_line),
    .out_valid(out_valid),
    .out_byte_0(out_byte_0), .out_byte_1(out_byte_1),
    .out_byte_2(out_byte_2), .out_byte_3(out_byte_3),
    .out_count(out_count), .out_line_end(out_line_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pixel_format_converter_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_byte_0(in_byte_0), .in_byte_1(in_byte_1),
    .in_byte_2(in_byte_2), .in_byte_3(in_byte_3),
    .in_last_in_line(in_last_in_line),
    .out_valid(out_valid),
    .out_byte_0(out_byte_0), .out_byte_1(out_byte_1),
    .out_byte_2(out_byte_2), .out_byte_3(out_byte_3),
    .out_count(out_count), .out_line_end(out_line_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .errors(chk_errors), .pending(chk_pending), .results_checked(chk_checked)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run limit
  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  // byte values biased toward the extremes
  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    case ($urandom_range(0, 7))
      0:       v = 8'h00;
      1:       v = 8'hFF;
      default: v = 8'($urandom);
    endcase
    return v;
  endfunction

  // one pixel transaction, returns at the falling edge after acceptance
  task automatic push_pixel(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3, input logic eol);
    start <= 1'b1;
    in_byte_0 <= b0;
    in_byte_1 <= b1;
    in_byte_2 <= b2;
    in_byte_3 <= b3;
    in_last_in_line <= eol;
    @(posedge clk);
    while (busy) @(posedge clk);
    pixels_sent++;
    @(negedge clk);
  endtask

  // sender idle cycles before the next pixel
  task automatic sender_gap();
    int n;
    n = 0;
    while (n < 40 && $urandom_range(0, 99) < send_idle_pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic random_pixel();
    sender_gap();
    push_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
               ($urandom_range(0, 7) == 0));
  endtask

  // write transaction: setup then access, returns at a falling edge
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
  endtask

  // drain the pipeline, then write all three registers
  task automatic apply_settings(input logic [2:0] src_code, input logic [2:0] tgt_code,
                                input logic trunc, input logic dirty);
    logic [31:0] d0;
    logic [31:0] d1;
    logic [31:0] d2;
    d0 = dirty ? $urandom : 32'd0;
    d1 = dirty ? $urandom : 32'd0;
    d2 = dirty ? $urandom : 32'd0;
    d0[2:0] = src_code;
    d1[2:0] = tgt_code;
    d2[0] = trunc;
    start <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
    cfg_write(REG_SOURCE_FORMAT, d0);
    cfg_write(REG_TARGET_FORMAT, d1);
    cfg_write(REG_TRUNCATE_MODE, d2);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    settings_applied++;
    @(negedge clk);
  endtask

  initial begin
    logic [2:0] src_code;
    logic [2:0] tgt_code;
    logic       trunc;
    rst_n = 1'b0;
    start = 1'b0;
    in_byte_0 = 8'd0;
    in_byte_1 = 8'd0;
    in_byte_2 = 8'd0;
    in_byte_3 = 8'd0;
    in_last_in_line = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 4'd0;
    pwdata = 32'd0;
    pixels_sent = 0;
    settings_applied = 0;
    send_idle_pct = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: identical formats pass through
    push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b0);

    // luma from RGB888, both extremes and a pure red
    apply_settings(FMT_RGB888, FMT_I8, 1'b0, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hAA, 1'b0);
    push_pixel(8'h00, 8'h00, 8'h00, 8'h55, 1'b1);
    push_pixel(8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);

    // alpha only into RGBA, color bytes zero
    apply_settings(FMT_A8, FMT_RGBA8888, 1'b0, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'h5A, 8'h00, 8'h00, 8'h00, 1'b1);

    // out-of-range codes saturate to RGBA8888 on both sides
    apply_settings(3'd7, 3'd5, 1'b0, 1'b0);
    push_pixel(8'hAA, 8'h55, 8'hFF, 8'h01, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);

    // truncate between equal sizes only relabels
    apply_settings(FMT_I8, FMT_A8, 1'b1, 1'b0);
    push_pixel(8'h9C, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'hFF, 8'h00, 8'h00, 8'h00, 1'b1);

    // truncate to one byte, then zero-fill up to four
    apply_settings(FMT_RGBA8888, FMT_A8, 1'b1, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    apply_settings(FMT_A8, 3'd6, 1'b1, 1'b0);
    push_pixel(8'h81, 8'hFF, 8'hFF, 8'hFF, 1'b1);

    // random phases: every format pair first, then two out-of-range code cases, then random settings
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < PHASES / 3) send_idle_pct = 14;
      else if (phase < 2 * PHASES / 3) send_idle_pct = 88;
      else send_idle_pct = 0;
      if (phase < 25) begin
        src_code = 3'(phase / 5);
        tgt_code = 3'(phase % 5);
        trunc = 1'b0;
      end else if (phase == 25) begin
        src_code = 3'd0;
        tgt_code = 3'd7;
        trunc = 1'b1;
      end else if (phase == 26) begin
        src_code = 3'd7;
        tgt_code = 3'd0;
        trunc = 1'b0;
      end else begin
        src_code = 3'($urandom_range(0, 7));
        tgt_code = 3'($urandom_range(0, 7));
        trunc = 1'($urandom_range(0, 1));
      end
      apply_settings(src_code, tgt_code, trunc, 1'b1);
      repeat (PIXELS_PER_PHASE) random_pixel();
    end

    // drain and let the pipeline settle
    start <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);

    $display("covered %0d pixels under %0d register settings, %0d results compared",
             pixels_sent, settings_applied, chk_checked);
    if (chk_pending != 0) $display("%0d predicted results never arrived", chk_pending);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
